// File: hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// shared types and constants of the clock time-set key front end
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd5;
    localparam logic [CFG_W-1:0] LONG_RST     = 8'd100;
    localparam logic [CFG_W-1:0] REPEAT_RST   = 8'd50;
    localparam logic [CFG_W-1:0] CEILING_RST  = 8'hf0;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_CHECK = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                minus_pressed;
        logic                plus_pressed;
        logic [HOUR_W-1:0]   load_hour;
        logic [MINUTE_W-1:0] load_minute;
    } cts_item_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic                time_changed;
    } cts_result_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cts_cfg_t;

endpackage

// File: hw/rtl/cts_in_reg.sv
// ----------------------------------------------------------------------------
// cts_in_reg
// input register stage: holds one accepted item until the core takes it
// ----------------------------------------------------------------------------
module cts_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cts_pkg::cts_item_t  in_item,
    output logic                item_valid,
    input  logic                item_take,
    output cts_pkg::cts_item_t  item
);
    import cts_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cts_item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/cts_core.sv
// ----------------------------------------------------------------------------
// cts_core
// key hold counters, heartbeat, step spacing and time registers
// ----------------------------------------------------------------------------
module cts_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cts_pkg::cts_cfg_t    cfg,
    input  logic                 step_en,
    input  cts_pkg::cts_item_t   item,
    output cts_pkg::cts_result_t result
);
    import cts_pkg::*;

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_reg;
    logic [CFG_W-1:0] repeat_reg;
    logic [CFG_W-1:0] ceiling_reg;

    logic [CFG_W-1:0]    minus_hold_reg, minus_hold_next;
    logic [CFG_W-1:0]    plus_hold_reg, plus_hold_next;
    logic [CFG_W-1:0]    heartbeat_reg, heartbeat_next;
    logic [CFG_W-1:0]    last_step_reg, last_step_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;

    logic [CFG_W-1:0]    elapsed;
    logic                spacing_ok;
    logic                step_up;
    logic                step_down;
    logic [MINUTE_W-1:0] up_minute, dn_minute;
    logic [HOUR_W-1:0]   up_hour, dn_hour;
    logic                changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            long_reg     <= LONG_RST;
            repeat_reg   <= REPEAT_RST;
            ceiling_reg  <= CEILING_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_DEBOUNCE: debounce_reg <= cfg.data;
                CFG_LONG:     long_reg     <= cfg.data;
                CFG_REPEAT:   repeat_reg   <= cfg.data;
                CFG_CEILING:  ceiling_reg  <= cfg.data;
                default:      ;
            endcase
        end
    end

    // spacing check, bypassed while either key is long pressed
    assign elapsed    = heartbeat_reg - last_step_reg;
    assign spacing_ok = (plus_hold_reg >= long_reg) || (minus_hold_reg >= long_reg)
                        || (elapsed >= repeat_reg);
    assign step_up    = spacing_ok && (plus_hold_reg > debounce_reg);
    assign step_down  = spacing_ok && (minus_hold_reg > debounce_reg);

    // minute up first, then down from that result
    always_comb
    begin
        up_minute = minute_reg;
        up_hour   = hour_reg;
        if (step_up)
        begin
            if (minute_reg >= MINUTE_MAX)
            begin
                up_minute = '0;
                up_hour   = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + 1'b1;
            end
            else
            begin
                up_minute = minute_reg + 1'b1;
            end
        end
        dn_minute = up_minute;
        dn_hour   = up_hour;
        if (step_down)
        begin
            if (up_minute == '0)
            begin
                dn_minute = MINUTE_MAX;
                dn_hour   = (up_hour == '0) ? HOUR_MAX : up_hour - 1'b1;
            end
            else
            begin
                dn_minute = up_minute - 1'b1;
            end
        end
    end

    always_comb
    begin
        minus_hold_next = minus_hold_reg;
        plus_hold_next  = plus_hold_reg;
        heartbeat_next  = heartbeat_reg;
        last_step_next  = last_step_reg;
        minute_next     = minute_reg;
        hour_next       = hour_reg;
        changed         = 1'b0;
        case (op_t'(item.op))
            OP_TICK:
            begin
                if (!item.minus_pressed)
                    minus_hold_next = '0;
                else if (minus_hold_reg < ceiling_reg)
                    minus_hold_next = minus_hold_reg + 1'b1;
                if (!item.plus_pressed)
                    plus_hold_next = '0;
                else if (plus_hold_reg < ceiling_reg)
                    plus_hold_next = plus_hold_reg + 1'b1;
                heartbeat_next = heartbeat_reg + 1'b1;
            end
            OP_CHECK:
            begin
                changed     = step_up || step_down;
                minute_next = dn_minute;
                hour_next   = dn_hour;
                if (changed)
                    last_step_next = heartbeat_reg;
            end
            OP_LOAD:
            begin
                hour_next   = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
                minute_next = (item.load_minute > MINUTE_MAX) ? MINUTE_MAX
                                                              : item.load_minute;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minus_hold_reg <= '0;
            plus_hold_reg  <= '0;
            heartbeat_reg  <= '0;
            last_step_reg  <= '0;
            minute_reg     <= '0;
            hour_reg       <= '0;
        end
        else if (step_en)
        begin
            minus_hold_reg <= minus_hold_next;
            plus_hold_reg  <= plus_hold_next;
            heartbeat_reg  <= heartbeat_next;
            last_step_reg  <= last_step_next;
            minute_reg     <= minute_next;
            hour_reg       <= hour_next;
        end
    end

    assign result.hour_now     = hour_next;
    assign result.minute_now   = minute_next;
    assign result.time_changed = changed;

endmodule

// File: hw/rtl/clock_time_set_keys_top.sv
// ----------------------------------------------------------------------------
// clock_time_set_keys_top
// time-set key front end: debounce, auto-repeat and hour/minute stepping
// ----------------------------------------------------------------------------
//
// channel   direction  fields (lowest bit up)
// s_axis    in         tdata: minus_pressed, plus_pressed, load_hour, load_minute
//                      tuser: op (0 tick, 1 check, 2 load)
// m_axis    out        tdata: hour_now, minute_now, time_changed
// cfg       in         cfg_we, cfg_index, cfg_data (8-bit registers 0..3)
//
// one item per cycle sustained while the output is taken; an item goes from input
// to output through the input register, then core logic into the result register
// the hold counters, heartbeat and time registers update as the item leaves
// the input register, so the next item sees them without a bubble
// a stalled output holds its item; the input register takes one more item
// behind it, then tready drops until the output is taken
// reset clears the valid flags and core state and loads the register defaults at once
//
module clock_time_set_keys_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // minus_pressed, plus_pressed, load_hour[4:0], load_minute[5:0], zero pad
    input  logic [cts_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // op[1:0]
    input  logic [cts_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hour_now[4:0], minute_now[5:0], time_changed, zero pad
    output logic [cts_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cts_pkg::CFG_W-1:0]         cfg_data
);
    import cts_pkg::*;

    cts_item_t   in_item;
    cts_item_t   item;
    logic        item_valid;
    logic        advance;
    cts_cfg_t    cfg;
    cts_result_t result;
    cts_result_t out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    // unpack the input item
    assign in_item.op            = s_axis_tuser;
    assign in_item.minus_pressed = s_axis_tdata[0];
    assign in_item.plus_pressed  = s_axis_tdata[1];
    assign in_item.load_hour     = s_axis_tdata[6:2];
    assign in_item.load_minute   = s_axis_tdata[12:7];

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // core works on the held item whenever the result register can take it
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    cts_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (advance),
        .item       (item)
    );

    cts_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (item),
        .result  (result)
    );

    // result register
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.time_changed, out_reg.minute_now,
                            out_reg.hour_now};

endmodule

// File: hw/rtl/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker
// port-level checks of the time-set key front end, bound to the top level
// ----------------------------------------------------------------------------
module cts_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [cts_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import cts_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // input back-pressure only when the output is full and stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // reported time is always a valid time of day
    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= HOUR_MAX)
        else $error("hour out of range");

    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:5] <= MINUTE_MAX)
        else $error("minute out of range");

endmodule

bind clock_time_set_keys_top cts_checker u_cts_checker (.*);
